>>> hw/rtl/crq_pkg.sv
package crq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int ID_W   = 8;
  localparam int DEV_W  = 32;
  localparam int LEN_W  = 8;
  localparam int POS_W  = 5;
  localparam int BYTE_W = 8;
  localparam int OLEN_W = 5;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 5;

  // slots in the request queue between front and back
  localparam int QUEUE_SLOTS = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_CMD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_DEV = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_PUSH,
    OP_POP,
    OP_FIND_CMD,
    OP_FIND_DEV,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              pos_ok;
    logic              len_ok;
    logic [ID_W-1:0]   cmd_id;
    logic [DEV_W-1:0]  dev_id;
    logic [ID_W-1:0]   snd_id;
    logic [LEN_W-1:0]  data_len;
    logic [POS_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] data_byte;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_FIND
  } back_state_t;

endpackage

>>> hw/rtl/command_ring_queue_with_search_top.sv
// channel   ports                           transfer
// input     start, busy, in_*               start high and busy low at the edge
// result    out_valid, out_*                one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_data  valid and ready high at the edge
//
// write, push, clear and unknown requests show their single result through the
// front register, queue slot and output register, one per cycle if none is ahead.
// pop: a registered memory read, then max(1, len) results back to back.
// find: one header per cycle through the header memory port, up to count.
// sync reset clears pointers and sets empty; memory contents are not cleared.
// results cannot be stalled; busy rises when the front register and the
// two-slot request queue are both full.
module command_ring_queue_with_search_top import crq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ID_W-1:0]   in_cmd_id,
  input  logic [DEV_W-1:0]  in_dev_id,
  input  logic [ID_W-1:0]   in_snd_id,
  input  logic [LEN_W-1:0]  in_data_len,
  input  logic [POS_W-1:0]  in_byte_pos,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              out_valid,
  output logic              out_ok,
  output logic [ID_W-1:0]   out_cmd_id,
  output logic [DEV_W-1:0]  out_dev_id,
  output logic [ID_W-1:0]   out_snd_id,
  output logic [OLEN_W-1:0] out_len,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              out_last,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_empty_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic fr_valid;
  req_t fr_req;
  logic q_ready;
  logic q_valid;
  req_t q_req;
  logic q_pop;

  crq_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_cmd_id    (in_cmd_id),
    .in_dev_id    (in_dev_id),
    .in_snd_id    (in_snd_id),
    .in_data_len  (in_data_len),
    .in_byte_pos  (in_byte_pos),
    .in_data_byte (in_data_byte),
    .req_valid    (fr_valid),
    .req          (fr_req),
    .req_ready    (q_ready)
  );

  crq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_req   (fr_req),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_req    (q_req),
    .pop        (q_pop)
  );

  crq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (q_valid),
    .req            (q_req),
    .req_pop        (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_cmd_id     (out_cmd_id),
    .out_dev_id     (out_dev_id),
    .out_snd_id     (out_snd_id),
    .out_len        (out_len),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res)
  );

  // payload bytes of one pop come out back to back
  a_pop_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid && !out_last |=> out_valid && out_byte_valid)
    else $error("pop burst broken");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_count == '0)
    else $error("empty queue with nonzero count");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_ok)
    else $error("payload byte on failed request");

endmodule

>>> hw/rtl/crq_front.sv
module crq_front import crq_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ID_W-1:0]   in_cmd_id,
  input  logic [DEV_W-1:0]  in_dev_id,
  input  logic [ID_W-1:0]   in_snd_id,
  input  logic [LEN_W-1:0]  in_data_len,
  input  logic [POS_W-1:0]  in_byte_pos,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              req_valid,
  output req_t              req,
  input  logic              req_ready
);

  logic hold_valid_r;
  req_t hold_r;
  req_t req_in;
  logic accept;

  always_comb begin
    req_in.cmd_id    = in_cmd_id;
    req_in.dev_id    = in_dev_id;
    req_in.snd_id    = in_snd_id;
    req_in.data_len  = in_data_len;
    req_in.byte_pos  = in_byte_pos;
    req_in.data_byte = in_data_byte;
    req_in.pos_ok    = int'(in_byte_pos) < MAX_PAYLOAD;
    req_in.len_ok    = int'(in_data_len) < MAX_PAYLOAD;
    unique case (in_cmd)
      CMD_WRITE:    req_in.op = OP_WRITE;
      CMD_PUSH:     req_in.op = OP_PUSH;
      CMD_POP:      req_in.op = OP_POP;
      CMD_FIND_CMD: req_in.op = OP_FIND_CMD;
      CMD_FIND_DEV: req_in.op = OP_FIND_DEV;
      CMD_CLEAR:    req_in.op = OP_CLEAR;
      default:      req_in.op = OP_NONE;
    endcase
  end

  assign busy      = hold_valid_r && !req_ready;
  assign accept    = start && !busy;
  assign req_valid = hold_valid_r;
  assign req       = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (req_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= req_in;
    end
  end

endmodule

>>> hw/rtl/crq_queue.sv
module crq_queue import crq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  req_t push_req,
  output logic push_ready,
  output logic pop_valid,
  output req_t pop_req,
  input  logic pop
);

  localparam int QW = $clog2(QUEUE_SLOTS);
  localparam int FW = $clog2(QUEUE_SLOTS + 1);

  req_t            slot_r [QUEUE_SLOTS];
  logic [QW-1:0]   wr_ptr_r;
  logic [QW-1:0]   rd_ptr_r;
  logic [FW-1:0]   fill_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = fill_r != FW'(QUEUE_SLOTS);
  assign pop_valid  = fill_r != '0;
  assign pop_req    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> hw/rtl/crq_back.sv
module crq_back import crq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  req_t              req,
  output logic              req_pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              out_valid,
  output logic              out_ok,
  output logic [ID_W-1:0]   out_cmd_id,
  output logic [DEV_W-1:0]  out_dev_id,
  output logic [ID_W-1:0]   out_snd_id,
  output logic [OLEN_W-1:0] out_len,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              out_last,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_empty_res
);

  localparam int IW     = $clog2(QUEUE_DEPTH);
  localparam int AW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PDEPTH = QUEUE_DEPTH * MAX_PAYLOAD;
  localparam int MW     = $clog2(PDEPTH);
  localparam int HW     = ID_W + DEV_W + ID_W + LW;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] p,
                                             input logic [AW-1:0] act);
    logic [AW-1:0] pe;
    pe = AW'(p) + AW'(1);
    return (pe >= act) ? '0 : IW'(pe);
  endfunction

  function automatic logic [AW-1:0] occupancy(input logic [IW-1:0] rd,
                                              input logic [IW-1:0] wr,
                                              input logic          emp,
                                              input logic [AW-1:0] act);
    if (emp) begin
      return '0;
    end
    if (wr > rd) begin
      return AW'(wr) - AW'(rd);
    end
    return act - (AW'(rd) - AW'(wr));
  endfunction

  // header and payload memories
  logic [HW-1:0]     hdr_mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0] pay_mem [PDEPTH];
  logic [HW-1:0]     hdr_rd_r;
  logic [BYTE_W-1:0] pay_rd_r;
  logic [IW-1:0]     hdr_raddr;
  logic              hdr_we;
  logic [HW-1:0]     hdr_wdata;
  logic [MW-1:0]     pay_raddr;
  logic [MW-1:0]     pay_waddr;
  logic              pay_we;

  back_state_t   state_r, state_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic          empty_r, empty_nxt;
  logic [AW-1:0] active_r, active_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [MW-1:0] base_r, base_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] remain_r, remain_nxt;
  req_t          req_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [ID_W-1:0]   out_cmd_id_r;
  logic [DEV_W-1:0]  out_dev_id_r;
  logic [ID_W-1:0]   out_snd_id_r;
  logic [OLEN_W-1:0] out_len_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_byte_valid_r;
  logic              out_last_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_res_r;

  logic [ID_W-1:0]  hdr_cmd;
  logic [DEV_W-1:0] hdr_dev;
  logic [ID_W-1:0]  hdr_snd;
  logic [LW-1:0]    hdr_len;
  logic             full;
  logic [AW-1:0]    occ_cur;
  logic [AW-1:0]    res_count;
  logic [IW-1:0]    rd_step;
  logic [MW-1:0]    pop_base;
  logic             pop_done;
  logic             hit;
  logic             cfg_big;
  logic [AW-1:0]    cfg_act;
  logic             emit;
  logic             res_ok;
  logic             res_hdr;
  logic             res_byte_valid;
  logic             res_last;

  assign hdr_cmd  = hdr_rd_r[HW-1 -: ID_W];
  assign hdr_dev  = hdr_rd_r[HW-ID_W-1 -: DEV_W];
  assign hdr_snd  = hdr_rd_r[LW +: ID_W];
  assign hdr_len  = hdr_rd_r[LW-1:0];

  assign full     = !empty_r && (wr_idx_r == rd_idx_r);
  assign occ_cur  = occupancy(rd_idx_r, wr_idx_r, empty_r, active_r);
  assign rd_step  = step_idx(rd_idx_r, active_r);
  assign pop_base = MW'(rd_idx_r * MAX_PAYLOAD);
  assign pop_done = (hdr_len == '0) || (({1'b0, k_r} + 1'b1) == {1'b0, hdr_len});
  assign hit      = (req_r.op == OP_FIND_CMD) ? (hdr_cmd == req_r.cmd_id)
                                              : (hdr_dev == req_r.dev_id);
  assign cfg_big  = int'(cfg_data) > QUEUE_DEPTH;
  assign cfg_act  = cfg_big ? AW'(QUEUE_DEPTH) :
                    (cfg_data == '0) ? AW'(1) : AW'(cfg_data);
  assign cfg_ready = state_r == BK_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_POP && !empty_r) begin
            state_nxt = BK_POP;
          end else if ((req.op == OP_FIND_CMD || req.op == OP_FIND_DEV) &&
                       occ_cur != '0) begin
            state_nxt = BK_FIND;
          end
        end
      end
      BK_POP: begin
        if (pop_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_FIND: begin
        if (hit || remain_r == AW'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    empty_nxt      = empty_r;
    active_nxt     = active_r;
    slot_nxt       = slot_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    scan_nxt       = scan_r;
    remain_nxt     = remain_r;
    req_pop        = 1'b0;
    hdr_raddr      = rd_idx_r;
    hdr_we         = 1'b0;
    hdr_wdata      = {req.cmd_id, req.dev_id, req.snd_id, LW'(req.data_len)};
    pay_raddr      = base_r;
    pay_we         = 1'b0;
    pay_waddr      = MW'(wr_idx_r * MAX_PAYLOAD) + MW'(req.byte_pos);
    emit           = 1'b0;
    res_ok         = 1'b0;
    res_hdr        = 1'b0;
    res_byte_valid = 1'b0;
    res_last       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          unique case (req.op) inside
            OP_WRITE: begin
              emit     = 1'b1;
              res_last = 1'b1;
              if (!full && req.pos_ok) begin
                pay_we = 1'b1;
                res_ok = 1'b1;
              end
            end
            OP_PUSH: begin
              emit     = 1'b1;
              res_last = 1'b1;
              if (!full && req.len_ok) begin
                hdr_we     = 1'b1;
                wr_idx_nxt = step_idx(wr_idx_r, active_r);
                empty_nxt  = 1'b0;
                res_ok     = 1'b1;
              end
            end
            OP_POP: begin
              if (empty_r) begin
                emit     = 1'b1;
                res_last = 1'b1;
              end else begin
                slot_nxt   = rd_idx_r;
                rd_idx_nxt = rd_step;
                empty_nxt  = rd_step == wr_idx_r;
                base_nxt   = pop_base;
                k_nxt      = '0;
                pay_raddr  = pop_base;
              end
            end
            OP_FIND_CMD, OP_FIND_DEV: begin
              if (occ_cur == '0) begin
                emit     = 1'b1;
                res_last = 1'b1;
              end else begin
                scan_nxt   = rd_step;
                remain_nxt = occ_cur;
              end
            end
            OP_CLEAR: begin
              rd_idx_nxt = '0;
              wr_idx_nxt = '0;
              empty_nxt  = 1'b1;
              emit       = 1'b1;
              res_ok     = 1'b1;
              res_last   = 1'b1;
            end
            default: begin
              emit     = 1'b1;
              res_last = 1'b1;
            end
          endcase
        end
      end
      BK_POP: begin
        hdr_raddr = slot_r;
        emit      = 1'b1;
        res_ok    = 1'b1;
        res_hdr   = 1'b1;
        res_last  = pop_done;
        if (hdr_len != '0) begin
          res_byte_valid = 1'b1;
          k_nxt          = k_r + 1'b1;
          pay_raddr      = base_r + MW'(k_r) + MW'(1);
        end
      end
      BK_FIND: begin
        hdr_raddr = scan_r;
        if (hit) begin
          emit     = 1'b1;
          res_ok   = 1'b1;
          res_last = 1'b1;
        end else if (remain_r == AW'(1)) begin
          emit     = 1'b1;
          res_last = 1'b1;
        end else begin
          remain_nxt = remain_r - AW'(1);
          scan_nxt   = step_idx(scan_r, active_r);
        end
      end
      default: begin
      end
    endcase
    if (cfg_valid && cfg_ready && empty_r) begin
      active_nxt = cfg_act;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
    end
  end

  assign res_count = occupancy(rd_idx_nxt, wr_idx_nxt, empty_nxt, active_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      empty_r     <= 1'b1;
      active_r    <= AW'(QUEUE_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      empty_r     <= empty_nxt;
      active_r    <= active_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    slot_r           <= slot_nxt;
    base_r           <= base_nxt;
    k_r              <= k_nxt;
    scan_r           <= scan_nxt;
    remain_r         <= remain_nxt;
    if (state_r == BK_IDLE && req_valid) begin
      req_r <= req;
    end
    out_ok_r         <= res_ok;
    out_cmd_id_r     <= res_hdr ? hdr_cmd : '0;
    out_dev_id_r     <= res_hdr ? hdr_dev : '0;
    out_snd_id_r     <= res_hdr ? hdr_snd : '0;
    out_len_r        <= res_hdr ? OLEN_W'(hdr_len) : '0;
    out_byte_r       <= res_byte_valid ? pay_rd_r : '0;
    out_byte_valid_r <= res_byte_valid;
    out_last_r       <= res_last;
    out_count_r      <= CNT_W'(res_count);
    out_empty_res_r  <= empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[wr_idx_r] <= hdr_wdata;
    end
    hdr_rd_r <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= req.data_byte;
    end
    pay_rd_r <= pay_mem[pay_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_cmd_id     = out_cmd_id_r;
  assign out_dev_id     = out_dev_id_r;
  assign out_snd_id     = out_snd_id_r;
  assign out_len        = out_len_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_last       = out_last_r;
  assign out_count      = out_count_r;
  assign out_empty_res  = out_empty_res_r;

endmodule
